// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock, disabled in reset.
`define CHK_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hw/rtl/wrh_pkg.sv -----
// Package: types, constants and helpers of the water ripple height field.
package wrh_pkg;
	localparam int unsigned MAX_COLS_DEF = 256;
	localparam int unsigned MAX_ROWS_DEF = 256;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPLASH_HALF = 2'd3;
	localparam logic [1:0] REQ_SPLASH = 2'd0;
	localparam logic [1:0] REQ_STEP = 2'd1;
	localparam logic [1:0] REQ_RENDER = 2'd2;
	localparam logic signed [15:0] SPLASH_VALUE = 16'sd255;
	localparam int unsigned DAMP_SHIFT = 5;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_SPLASH, ST_STEP_RD, ST_STEP_WAIT, ST_STEP_WR,
		ST_REND_RD, ST_REND_WAIT, ST_REND_CALC, ST_OUT
	} state_t;

	typedef struct packed {
		logic [11:0] src_x;
		logic [11:0] src_y;
		logic        displaced;
	} result_t;

	// next-frame value of one cell: half neighbor sum minus previous, damped, saturated
	function automatic logic signed [15:0] ripple_next(input logic signed [17:0] sum,
			input logic signed [15:0] prev);
		logic signed [18:0] v;
		logic signed [18:0] w;
		begin
			v = 19'(sum >>> 1) - 19'(prev);
			w = v - (v >>> DAMP_SHIFT);
			if (w > 19'sd32767) ripple_next = 16'sh7fff;
			else if (w < -19'sd32768) ripple_next = 16'sh8000;
			else ripple_next = w[15:0];
		end
	endfunction
endpackage

// ----- hw/rtl/wrh_ram.sv -----
// Generic single-port-write, one-read synchronous RAM with registered read.
module wrh_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/water_ripple_heightfield.sv -----
// Top level of the water ripple height field.
//  channel | signals                                       | payload
//  s_axis  | s_tvalid s_tready s_tuser[1:0] s_tdata[23:0] | req_type; pos_x, pos_y
//  m_axis  | m_tvalid m_tready m_tdata[23:0] m_tuser      | src_x, src_y; displaced
//  cfg     | cfg_we cfg_idx cfg_wdata                      | register write
// After reset a clearing pass over all 2**(CW+RW) addresses (65536 by default) zeroes both grids.
// Splash: one covered cell written per cycle. Render: four reads per transaction.
// Step: five reads then one write per interior cell.
// An unknown request or an empty step goes from idle straight to the output state.
// One item in flight; a stalled result waits in the output register while the next item runs.
module water_ripple_heightfield #(
	parameter int unsigned MAX_COLS = wrh_pkg::MAX_COLS_DEF,
	parameter int unsigned MAX_ROWS = wrh_pkg::MAX_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [1:0]                    s_tuser, // req_type[1:0]
	input  logic [23:0]                   s_tdata, // pos_x[11:0] pos_y[23:12]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata, // src_x[11:0] src_y[23:12]
	output logic                          m_tuser, // displaced[0]
	input  logic                          cfg_we,
	input  logic [wrh_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [wrh_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import wrh_pkg::*;
	localparam int unsigned CW = $clog2(MAX_COLS);
	localparam int unsigned RW = $clog2(MAX_ROWS);
	localparam int unsigned AW = CW + RW;
	localparam int unsigned DEPTH = 1 << AW;

	logic [12:0] img_w_q, img_h_q;
	logic [2:0]  shift_q;
	logic [6:0]  half_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= 13'd1024; img_h_q <= 13'd1024; shift_q <= 3'd2; half_q <= 7'd4;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_IMAGE_WIDTH:  img_w_q <= cfg_wdata;
				REG_IMAGE_HEIGHT: img_h_q <= cfg_wdata;
				REG_SCALE_SHIFT:  shift_q <= cfg_wdata[2:0];
				REG_SPLASH_HALF:  half_q <= cfg_wdata[6:0];
			endcase
		end
	end

	// clamped image size and grid size
	logic [12:0] w_c, h_c, cols_raw, rows_raw;
	logic [11:0] cols, rows; // clamped to MAX_COLS and MAX_ROWS; fits 12 bits while MAX <= 4095
	always_comb begin
		w_c = (img_w_q == 13'd0) ? 13'd1 : (img_w_q > 13'd4096 ? 13'd4096 : img_w_q);
		h_c = (img_h_q == 13'd0) ? 13'd1 : (img_h_q > 13'd4096 ? 13'd4096 : img_h_q);
		cols_raw = w_c >> shift_q;
		rows_raw = h_c >> shift_q;
		cols = (cols_raw > 13'(MAX_COLS)) ? 12'(MAX_COLS) : cols_raw[11:0];
		rows = (rows_raw > 13'(MAX_ROWS)) ? 12'(MAX_ROWS) : rows_raw[11:0];
	end

	state_t state_q, state_d;
	logic cur_b_q, cur_b_d;
	logic signed [13:0] x_q, y_q, x_d, y_d, xlo_q, xhi_q, yhi_q, xlo_d, xhi_d, yhi_d;
	logic [2:0] ph_q, ph_d;
	logic signed [17:0] acc_q, acc_d;
	logic signed [16:0] n0_q, n0_d, n1_q, n1_d;
	logic [AW:0] clr_q, clr_d;
	result_t res_q, res_d;
	result_t out_q;
	logic out_load;
	logic m_valid_q, m_valid_d;

	logic we_a, we_b;
	logic [AW-1:0] waddr, raddr_a, raddr_b, raddr;
	logic [15:0] wdata, rd_a, rd_b;
	wrh_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_grid_a (.clk(clk), .we(we_a), .waddr(waddr),
		.wdata(wdata), .raddr(raddr_a), .rdata(rd_a));
	wrh_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_grid_b (.clk(clk), .we(we_b), .waddr(waddr),
		.wdata(wdata), .raddr(raddr_b), .rdata(rd_b));

	logic signed [15:0] cur_rd, oth_rd;
	assign cur_rd = cur_b_q ? rd_b : rd_a;
	assign oth_rd = cur_b_q ? rd_a : rd_b;

	function automatic logic [AW-1:0] addr_of(input logic signed [13:0] x,
			input logic signed [13:0] y);
		addr_of = {y[RW-1:0], x[CW-1:0]};
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata = {out_q.src_y, out_q.src_x};
	assign m_tuser = out_q.displaced;

	logic signed [13:0] gx, gy, lo, hi, rhi;
	logic signed [17:0] sx, sy;
	always_comb begin
		gx = 14'(s_tdata[11:0] >> shift_q);
		gy = 14'(s_tdata[23:12] >> shift_q);
		lo = 14'sd1;
		state_d = state_q; cur_b_d = cur_b_q; x_d = x_q; y_d = y_q; ph_d = ph_q;
		xlo_d = xlo_q; xhi_d = xhi_q; yhi_d = yhi_q; acc_d = acc_q; n0_d = n0_q; n1_d = n1_q;
		clr_d = clr_q; res_d = res_q; m_valid_d = m_valid_q; out_load = 1'b0;
		we_a = 1'b0; we_b = 1'b0; waddr = addr_of(x_q, y_q); wdata = '0;
		raddr = addr_of(x_q, y_q);
		hi = 14'(cols) - 14'sd1;
		rhi = 14'(rows) - 14'sd1;
		sx = '0; sy = '0;
		if (m_valid_q && m_tready) m_valid_d = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				we_a = 1'b1; we_b = 1'b1; waddr = clr_q[AW-1:0];
				clr_d = clr_q + 1'b1;
				if (clr_q == (AW+1)'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					res_d = '0;
					unique case (s_tuser)
						REQ_SPLASH: begin
							// clip square to interior
							xlo_d = gx - 14'(half_q); xhi_d = gx + 14'(half_q);
							y_d = gy - 14'(half_q); yhi_d = gy + 14'(half_q);
							if (xlo_d < lo) xlo_d = lo;
							if (xhi_d > hi) xhi_d = hi;
							if (y_d < lo) y_d = lo;
							if (yhi_d > rhi) yhi_d = rhi;
							x_d = xlo_d;
							state_d = (xlo_d < xhi_d && y_d < yhi_d) ? ST_SPLASH : ST_OUT;
						end
						REQ_STEP: begin
							x_d = 14'sd1; y_d = 14'sd1; ph_d = '0;
							if (cols == 12'd0 || rows == 12'd0) state_d = ST_OUT;
							else if (cols < 12'd3 || rows < 12'd3) begin
								cur_b_d = ~cur_b_q; state_d = ST_OUT;
							end else state_d = ST_STEP_RD;
						end
						REQ_RENDER: begin
							x_d = gx; y_d = gy; ph_d = '0;
							res_d.src_x = s_tdata[11:0]; res_d.src_y = s_tdata[23:12];
							if (gx > 14'sd0 && gx < hi && gy > 14'sd0 && gy < rhi)
								state_d = ST_REND_RD;
							else state_d = ST_OUT;
						end
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_SPLASH: begin
				we_a = ~cur_b_q; we_b = cur_b_q; wdata = SPLASH_VALUE;
				if (x_q + 14'sd1 >= xhi_q) begin
					x_d = xlo_q; y_d = y_q + 14'sd1;
					if (y_q + 14'sd1 >= yhi_q) state_d = ST_OUT;
				end else x_d = x_q + 14'sd1;
			end
			ST_STEP_RD, ST_STEP_WAIT: begin
				// phases 0..3 neighbors of current, 4 same cell of other; data arrives in the next cycle
				unique case (ph_q)
					3'd0: raddr = addr_of(x_q - 14'sd1, y_q);
					3'd1: raddr = addr_of(x_q + 14'sd1, y_q);
					3'd2: raddr = addr_of(x_q, y_q - 14'sd1);
					3'd3: raddr = addr_of(x_q, y_q + 14'sd1);
					default: raddr = addr_of(x_q, y_q);
				endcase
				if (state_q == ST_STEP_RD) acc_d = '0;
				else acc_d = acc_q + 18'(cur_rd);
				ph_d = ph_q + 3'd1;
				state_d = ST_STEP_WAIT;
				if (ph_q == 3'd4) state_d = ST_STEP_WR;
			end
			ST_STEP_WR: begin
				we_a = cur_b_q; we_b = ~cur_b_q;
				wdata = ripple_next(acc_q, oth_rd);
				ph_d = '0;
				state_d = ST_STEP_RD;
				if (x_q + 14'sd1 >= hi) begin
					x_d = 14'sd1; y_d = y_q + 14'sd1;
					if (y_q + 14'sd1 >= rhi) begin
						cur_b_d = ~cur_b_q; state_d = ST_OUT;
					end
				end else x_d = x_q + 14'sd1;
			end
			ST_REND_RD, ST_REND_WAIT: begin
				unique case (ph_q)
					3'd0: raddr = addr_of(x_q - 14'sd1, y_q);
					3'd1: raddr = addr_of(x_q + 14'sd1, y_q);
					3'd2: raddr = addr_of(x_q, y_q - 14'sd1);
					default: raddr = addr_of(x_q, y_q + 14'sd1);
				endcase
				if (state_q == ST_REND_WAIT) begin
					unique case (ph_q)
						3'd1: n0_d = 17'(cur_rd);
						3'd2: n0_d = n0_q - 17'(cur_rd);
						3'd3: n1_d = 17'(cur_rd);
						default: n1_d = n1_q - 17'(cur_rd);
					endcase
				end
				ph_d = ph_q + 3'd1;
				state_d = (ph_q == 3'd4) ? ST_REND_CALC : ST_REND_WAIT;
			end
			ST_REND_CALC: begin
				sx = 18'(res_q.src_x) + 18'(n0_q);
				sy = 18'(res_q.src_y) + 18'(n1_q);
				if (sx < 18'sd0) sx = '0;
				else if (sx > 18'(w_c) - 18'sd1) sx = 18'(w_c) - 18'sd1;
				if (sy < 18'sd0) sy = '0;
				else if (sy > 18'(h_c) - 18'sd1) sy = 18'(h_c) - 18'sd1;
				res_d.src_x = sx[11:0]; res_d.src_y = sy[11:0]; res_d.displaced = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!m_valid_q || m_tready) begin
					m_valid_d = 1'b1; out_load = 1'b1; state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
	assign raddr_a = raddr;
	assign raddr_b = raddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; cur_b_q <= 1'b0; clr_q <= '0; m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d; cur_b_q <= cur_b_d; clr_q <= clr_d; m_valid_q <= m_valid_d;
		end
	end
	always_ff @(posedge clk) begin
		x_q <= x_d; y_q <= y_d; ph_q <= ph_d; xlo_q <= xlo_d; xhi_q <= xhi_d; yhi_q <= yhi_d;
		acc_q <= acc_d; n0_q <= n0_d; n1_q <= n1_d; res_q <= res_d;
		if (out_load) out_q <= res_q;
	end
endmodule

// ----- hw/rtl/wrh_checker.sv -----
// Port-level checker of the water ripple height field and its bind.
`include "assert_macros.svh"
module wrh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);
	`CHK_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output dropped while stalled")
	`CHK_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready, "second item taken while busy")
	`CHK_IMPL(a_out_known, clk, arst_n, m_tvalid, !$isunknown(m_tdata) && !$isunknown(m_tuser), "result has unknown bits")
endmodule

bind water_ripple_heightfield wrh_checker u_wrh_checker (.clk(clk), .arst_n(arst_n),
	.s_tvalid(s_tvalid), .s_tready(s_tready), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser));

// ----- dv/testbench.sv -----
// Testbench of the water ripple height field: directed, extreme and random requests checked
// against an in-bench model of both height grids.
`timescale 1ns / 1ps
module testbench;
	import wrh_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int LIMIT = 30000000;
	localparam int NCELL = 65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [1:0] s_tuser = '0;
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	water_ripple_heightfield dut (.*);

	always #2 clk = ~clk;

	shortint height[2][NCELL];
	bit cur_b;
	int img_w_reg, img_h_reg, shift_reg, half_reg;
	result_t expected_q[$];
	int errors, cycles, send_idle_pct, stall_pct;
	int n_splash, n_step, n_render, n_unknown;

	function automatic int clampi(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int eff_w();
		return clampi(img_w_reg, 1, 4096);
	endfunction

	function automatic int eff_h();
		return clampi(img_h_reg, 1, 4096);
	endfunction

	function automatic int cols();
		int c;
		c = eff_w() >> shift_reg;
		return c > 256 ? 256 : c;
	endfunction

	function automatic int rows();
		int r;
		r = eff_h() >> shift_reg;
		return r > 256 ? 256 : r;
	endfunction

	function automatic result_t ripple_predict(logic [1:0] req, int px, int py);
		result_t r;
		int c, rw, bx, by, i, s, v, dx, dy;
		r = '0;
		c = cols();
		rw = rows();
		bx = px >> shift_reg;
		by = py >> shift_reg;
		case (req)
			REQ_SPLASH: begin
				for (int y = by - half_reg; y < by + half_reg; y++)
					for (int x = bx - half_reg; x < bx + half_reg; x++)
						if (y >= 1 && y < rw - 1 && x >= 1 && x < c - 1)
							height[cur_b][y*256 + x] = 255;
			end
			REQ_STEP: begin
				if (c != 0 && rw != 0) begin
					for (int y = 1; y < rw - 1; y++)
						for (int x = 1; x < c - 1; x++) begin
							i = y*256 + x;
							s = height[cur_b][i-1] + height[cur_b][i+1]
								+ height[cur_b][i-256] + height[cur_b][i+256];
							v = (s >>> 1) - height[!cur_b][i];
							v = v - (v >>> 5);
							height[!cur_b][i] = shortint'(clampi(v, -32768, 32767));
						end
					cur_b = !cur_b;
				end
			end
			REQ_RENDER: begin
				if (bx > 0 && bx < c - 1 && by > 0 && by < rw - 1) begin
					i = by*256 + bx;
					dx = height[cur_b][i-1] - height[cur_b][i+1];
					dy = height[cur_b][i-256] - height[cur_b][i+256];
					r.src_x = 12'(clampi(px + dx, 0, eff_w() - 1));
					r.src_y = 12'(clampi(py + dy, 0, eff_h() - 1));
					r.displaced = 1'b1;
				end else begin
					r.src_x = 12'(px);
					r.src_y = 12'(py);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// called at a rising edge; returns at the edge of acceptance, or at a later edge with s_tvalid low when it idles
	task automatic send_req(logic [1:0] req, int px, int py);
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {12'(py), 12'(px)};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		expected_q.insert(expected_q.size(), ripple_predict(req, px, py));
		case (req)
			REQ_SPLASH: n_splash++;
			REQ_STEP: n_step++;
			REQ_RENDER: n_render++;
			default: n_unknown++;
		endcase
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
			@(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= CFG_DATA_W'(val);
		@(posedge clk);
		case (idx)
			REG_IMAGE_WIDTH: img_w_reg = val & 16'h1fff;
			REG_IMAGE_HEIGHT: img_h_reg = val & 16'h1fff;
			REG_SCALE_SHIFT: shift_reg = val & 7;
			default: half_reg = val & 8'h7f;
		endcase
	endtask

	task automatic set_config(int w, int h, int sh, int half);
		drain();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_SCALE_SHIFT, sh);
		write_reg(REG_SPLASH_HALF, half);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

	always @(negedge clk) begin
		result_t got, exp_r;
		if (m_tvalid && m_tready) begin
			got.src_x = m_tdata[11:0];
			got.src_y = m_tdata[23:12];
			got.displaced = m_tuser;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h %b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (got.src_x !== exp_r.src_x || got.src_y !== exp_r.src_y
						|| got.displaced !== exp_r.displaced) begin
					$display("%0t: mismatch expected x=%0d y=%0d d=%0d actual x=%0d y=%0d d=%0d",
						$time, exp_r.src_x, exp_r.src_y, exp_r.displaced,
						got.src_x, got.src_y, got.displaced);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic test_directed();
		// reset config: 256x256 grid, no steps here
		send_req(REQ_SPLASH, 512, 512);
		send_req(REQ_RENDER, 512, 512);
		send_req(REQ_RENDER, 508, 520);
		send_req(REQ_RENDER, 0, 0);
		send_req(REQ_RENDER, 4095, 4095);
		send_req(REQ_UNKNOWN, 4095, 4095);
		set_config(40, 36, 2, 2);
		send_req(REQ_SPLASH, 0, 0);
		send_req(REQ_SPLASH, 20, 16);
		send_req(REQ_RENDER, 20, 16);
		send_req(REQ_STEP, 0, 0);
		send_req(REQ_RENDER, 16, 12);
		send_req(REQ_STEP, 4095, 4095);
		send_req(REQ_RENDER, 24, 20);
		send_req(REQ_RENDER, 4, 4);
		send_req(REQ_RENDER, 39, 35);
		send_req(REQ_STEP, 0, 0);
		send_req(REQ_RENDER, 12, 8);
	endtask

	task automatic test_extremes();
		set_config(0, 8191, 7, 127);
		send_req(REQ_SPLASH, 0, 0);
		send_req(REQ_STEP, 0, 0);
		send_req(REQ_RENDER, 4095, 0);
		set_config(4096, 4, 0, 64);
		send_req(REQ_SPLASH, 4095, 2);
		send_req(REQ_SPLASH, 100, 1);
		send_req(REQ_STEP, 0, 0);
		send_req(REQ_RENDER, 100, 1);
		send_req(REQ_RENDER, 4094, 2);
		set_config(6, 6, 1, 0);
		send_req(REQ_SPLASH, 2, 2);
		send_req(REQ_STEP, 0, 0);
		send_req(REQ_RENDER, 3, 3);
		drain();
	endtask

	task automatic test_random(int items);
		int sh, k, px, py, w, h;
		logic [1:0] req;
		for (int n = 0; n < items; n++) begin
			if (n % 60 == 0) begin
				sh = $urandom_range(9) == 0 ? $urandom_range(7, 5) : $urandom_range(3);
				if (sh >= 5) begin
					w = $urandom_range(8191);
					h = $urandom_range(8191);
				end else begin
					w = ($urandom_range(12, 3) << sh) + $urandom_range((1 << sh) - 1);
					h = ($urandom_range(12, 3) << sh) + $urandom_range((1 << sh) - 1);
				end
				set_config(w, h, sh, $urandom_range(19) == 0 ? $urandom_range(127)
					: $urandom_range(6));
			end
			k = $urandom_range(99);
			req = k < 30 ? REQ_SPLASH : k < 45 ? REQ_STEP : k < 96 ? REQ_RENDER : REQ_UNKNOWN;
			if ($urandom_range(99) < 70) begin
				px = $urandom_range(eff_w() - 1);
				py = $urandom_range(eff_h() - 1);
			end else begin
				px = $urandom_range(4095);
				py = $urandom_range(4095);
			end
			send_req(req, px, py);
			if (n == items / 2) drain();
		end
	endtask

	initial begin
		img_w_reg = 1024;
		img_h_reg = 1024;
		shift_reg = 2;
		half_reg = 4;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extremes();
		send_idle_pct = 0; stall_pct = 0;
		test_random(375);
		send_idle_pct = 75; stall_pct = 0;
		test_random(375);
		send_idle_pct = 0; stall_pct = 75;
		test_random(375);
		send_idle_pct = 22; stall_pct = 22;
		test_random(375);
		drain();
		repeat (100) @(posedge clk);
		$display("Covered %0d splash, %0d step, %0d render and %0d unknown requests",
			n_splash, n_step, n_render, n_unknown);
		$display("over directed, extreme and random grid settings; %0d errors", errors);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
